// File: rtl/core/mi4_pkg.sv
// shared types and constants for the 4x4 matrix inverse block
// no dependencies
package mi4_pkg;

    localparam int CHUNK_W = 32;
    localparam int ELEM_W  = 32;
    localparam int PROD_W  = 65;
    localparam int ADJ_W   = 97;
    localparam int DET_W   = 130;
    localparam int DETM_W  = 129;
    localparam int QB_W    = 33;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ADJ,
        ST_DET,
        ST_DET_END,
        ST_SING,
        ST_DIV_RD,
        ST_DIV_LD,
        ST_DIV_CHK,
        ST_DIV_RUN,
        ST_DIV_OUT
    } state_t;

    // column of each factor of the six minor terms, factor n sits on minor row n
    localparam logic [1:0] TERM_COL [6][3] = '{
        '{2'd0, 2'd1, 2'd2},
        '{2'd0, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2},
        '{2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1},
        '{2'd2, 2'd1, 2'd0}
    };

    // terms that enter the minor with a minus sign
    localparam logic [5:0] TERM_NEG = 6'b100110;

    // matrix address of one factor; adjugate k = i*4+j drops row j and column i
    function automatic logic [3:0] elem_addr(input logic [3:0] k, input logic [2:0] t,
                                             input logic [1:0] f);
        logic [1:0] ci;
        logic [1:0] row;
        logic [1:0] col;
        ci  = TERM_COL[t][f];
        row = f + {1'b0, (f >= k[1:0])};
        col = ci + {1'b0, (ci >= k[3:2])};
        return {row, col};
    endfunction

endpackage

// File: rtl/core/matrix_inverse_4x4.sv
// 4x4 matrix inverse by adjugate and long division, top level
// depends on mi4_pkg and mi4_ram
//
// sixteen signed fixed-point elements enter in row-major order, one per transfer, at one
// per cycle into the matrix ram. after the sixteenth the block stalls its input while it
// builds the sixteen adjugate terms exactly (six 3-products each) through one shared
// 33x32 multiplier, storing them in a second ram; then it forms the determinant. a zero
// determinant gives one result flagged singular. otherwise each of the sixteen results
// is trunc(adj * 2^(2*FRAC_BITS) / det) from a restoring divider that retires one
// quotient bit a cycle, saturated to 32 bits with clipped set. the next matrix is taken
// once the last result sits in the output register.
module matrix_inverse_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           element_valid,
    output logic                           element_stall,
    input  logic signed [mi4_pkg::ELEM_W-1:0] element,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic signed [mi4_pkg::ELEM_W-1:0] value,
    output logic [3:0]                     position,
    output logic                           last,
    output logic                           singular,
    output logic                           clipped
);
    import mi4_pkg::*;

    localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
    localparam int CMP_W = DETM_W + QB_W;

    // control
    state_t      state_reg, state_next;
    logic [3:0]  load_cnt_reg, load_cnt_next;
    logic [3:0]  k_reg, k_next;
    logic [2:0]  term_reg, term_next;
    logic [2:0]  ph_reg, ph_next;
    logic [5:0]  bit_cnt_reg, bit_cnt_next;
    logic        prod_vld_reg, prod_vld_next;
    logic        result_valid_reg, result_valid_next;

    // datapath
    logic signed [ELEM_W-1:0]  a_reg, a_next;
    logic signed [63:0]        p_reg, p_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic [1:0]                prod_sh_reg, prod_sh_next;
    logic                      prod_neg_reg, prod_neg_next;
    logic                      prod_det_reg, prod_det_next;
    logic signed [ADJ_W-1:0]   acc_reg, acc_next;
    logic signed [DET_W-1:0]   det_reg, det_next;
    logic                      det_neg_reg, det_neg_next;
    logic [DETM_W-1:0]         dmag_reg, dmag_next;
    logic [CMP_W-1:0]          rem_reg, rem_next;
    logic [CMP_W-1:0]          dsh_reg, dsh_next;
    logic [QB_W-1:0]           q_reg, q_next;
    logic                      neg_reg, neg_next;
    logic                      over_reg, over_next;
    logic signed [ELEM_W-1:0]  value_reg, value_next;
    logic [3:0]                position_reg, position_next;
    logic                      last_reg, last_next;
    logic                      singular_reg, singular_next;
    logic                      clipped_reg, clipped_next;

    // shared multiplier
    logic signed [32:0]        mul_a;
    logic signed [31:0]        mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    // rams
    logic                      in_xfer;
    logic [3:0]                mat_raddr;
    logic signed [ELEM_W-1:0]  mat_rdata;
    logic                      adj_we;
    logic signed [ADJ_W-1:0]   adj_wdata;
    logic [3:0]                adj_raddr;
    logic signed [ADJ_W-1:0]   adj_rdata;

    // misc combinational
    logic                      out_free;
    logic                      cof_neg;
    logic [1:0]                fsel;
    logic signed [DET_W-1:0]   add_ext, addend;
    logic signed [NUM_W-1:0]   num;
    logic [NUM_W-1:0]          mag;
    logic                      ge;
    logic [QB_W-1:0]           limit;
    logic                      clip;

    assign element_stall = (state_reg != ST_LOAD);
    assign in_xfer       = element_valid && !element_stall;
    assign out_free      = !result_valid_reg || !result_stall;
    assign mul_p         = mul_a * mul_b;
    assign cof_neg       = k_reg[2] ^ k_reg[0];

    assign result_valid  = result_valid_reg;
    assign value         = value_reg;
    assign position      = position_reg;
    assign last          = last_reg;
    assign singular      = singular_reg;
    assign clipped       = clipped_reg;

    mi4_ram #(.WIDTH(ELEM_W), .DEPTH(16)) u_mat_ram (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (load_cnt_reg),
        .wdata (element),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    mi4_ram #(.WIDTH(ADJ_W), .DEPTH(16)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (k_reg),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && load_cnt_reg == 4'd15)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:
            begin
                if (k_reg == 4'd15 && term_reg == 3'd5 && ph_reg == 3'd5)
                begin
                    state_next = ST_DET;
                end
            end
            ST_DET:
            begin
                if (k_reg[1:0] == 2'd3 && ph_reg == 3'd4)
                begin
                    state_next = ST_DET_END;
                end
            end
            ST_DET_END:
            begin
                state_next = (det_reg == '0) ? ST_SING : ST_DIV_RD;
            end
            ST_SING:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_DIV_RD:  state_next = ST_DIV_LD;
            ST_DIV_LD:  state_next = ST_DIV_CHK;
            ST_DIV_CHK:
            begin
                state_next = over_next ? ST_DIV_OUT : ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_DIV_OUT;
                end
            end
            ST_DIV_OUT:
            begin
                if (out_free)
                begin
                    state_next = (k_reg == 4'd15) ? ST_LOAD : ST_DIV_RD;
                end
            end
            default:    state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        load_cnt_next     = load_cnt_reg;
        k_next            = k_reg;
        term_next         = term_reg;
        ph_next           = ph_reg;
        bit_cnt_next      = bit_cnt_reg;
        prod_vld_next     = 1'b0;
        result_valid_next = result_valid_reg && result_stall;
        a_next            = a_reg;
        p_next            = p_reg;
        prod_next         = mul_p;
        prod_sh_next      = 2'd0;
        prod_neg_next     = 1'b0;
        prod_det_next     = 1'b0;
        acc_next          = acc_reg;
        det_next          = det_reg;
        det_neg_next      = det_neg_reg;
        dmag_next         = dmag_reg;
        rem_next          = rem_reg;
        dsh_next          = dsh_reg;
        q_next            = q_reg;
        neg_next          = neg_reg;
        over_next         = over_reg;
        value_next        = value_reg;
        position_next     = position_reg;
        last_next         = last_reg;
        singular_next     = singular_reg;
        clipped_next      = clipped_reg;
        mul_a             = '0;
        mul_b             = '0;
        mat_raddr         = '0;
        adj_raddr         = k_reg;
        adj_we            = 1'b0;
        fsel              = (ph_reg >= 3'd2) ? 2'd2 : ph_reg[1:0];
        num               = '0;
        mag               = '0;
        ge                = rem_reg >= dsh_reg;
        limit             = neg_reg ? QB_W'(33'h080000000) : QB_W'(33'h07FFFFFFF);
        clip              = over_reg || (q_reg > limit);

        // product accumulation, one chunk a cycle
        add_ext = DET_W'(prod_reg);
        case (prod_sh_reg)
            2'd0:    addend = add_ext;
            2'd1:    addend = add_ext <<< CHUNK_W;
            default: addend = add_ext <<< (2 * CHUNK_W);
        endcase
        if (prod_neg_reg)
        begin
            addend = -addend;
        end
        if (prod_vld_reg)
        begin
            if (prod_det_reg)
            begin
                det_next = det_reg + addend;
            end
            else
            begin
                acc_next = acc_reg + addend[ADJ_W-1:0];
            end
        end
        // finished adjugate term including the last chunk
        adj_wdata = acc_next;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15)
                    begin
                        k_next    = '0;
                        term_next = '0;
                        ph_next   = '0;
                        acc_next  = '0;
                    end
                end
            end
            ST_ADJ:
            begin
                mat_raddr = elem_addr(k_reg, term_reg, fsel);
                case (ph_reg)
                    3'd1:
                    begin
                        a_next = mat_rdata;
                    end
                    3'd2:
                    begin
                        mul_a  = 33'(a_reg);
                        mul_b  = mat_rdata;
                        p_next = mul_p[63:0];
                    end
                    3'd3:
                    begin
                        mul_a         = {1'b0, p_reg[31:0]};
                        mul_b         = mat_rdata;
                        prod_vld_next = 1'b1;
                        prod_sh_next  = 2'd0;
                        prod_neg_next = TERM_NEG[term_reg] ^ cof_neg;
                    end
                    3'd4:
                    begin
                        mul_a         = {p_reg[63], p_reg[63:32]};
                        mul_b         = mat_rdata;
                        prod_vld_next = 1'b1;
                        prod_sh_next  = 2'd1;
                        prod_neg_next = TERM_NEG[term_reg] ^ cof_neg;
                    end
                    default: ;
                endcase
                if (ph_reg == 3'd5)
                begin
                    ph_next = '0;
                    if (term_reg == 3'd5)
                    begin
                        adj_we    = 1'b1;
                        acc_next  = '0;
                        term_next = '0;
                        k_next    = k_reg + 4'd1;
                        if (k_reg == 4'd15)
                        begin
                            det_next = '0;
                        end
                    end
                    else
                    begin
                        term_next = term_reg + 3'd1;
                    end
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            ST_DET:
            begin
                // adjugate acc is free now; clear it once the last term is written
                acc_next      = '0;
                mat_raddr     = {2'b00, k_reg[1:0]};
                adj_raddr     = {k_reg[1:0], 2'b00};
                mul_b         = mat_rdata;
                prod_det_next = 1'b1;
                case (ph_reg)
                    3'd1:
                    begin
                        mul_a         = {1'b0, adj_rdata[31:0]};
                        prod_vld_next = 1'b1;
                        prod_sh_next  = 2'd0;
                    end
                    3'd2:
                    begin
                        mul_a         = {1'b0, adj_rdata[63:32]};
                        prod_vld_next = 1'b1;
                        prod_sh_next  = 2'd1;
                    end
                    3'd3:
                    begin
                        mul_a         = adj_rdata[96:64];
                        prod_vld_next = 1'b1;
                        prod_sh_next  = 2'd2;
                    end
                    default: ;
                endcase
                if (ph_reg == 3'd4)
                begin
                    ph_next = '0;
                    k_next  = k_reg + 4'd1;
                end
                else
                begin
                    ph_next = ph_reg + 3'd1;
                end
            end
            ST_DET_END:
            begin
                k_next       = '0;
                det_neg_next = det_reg[DET_W-1];
                dmag_next    = det_reg[DET_W-1] ? DETM_W'(-det_reg) : DETM_W'(det_reg);
            end
            ST_SING:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    value_next        = '0;
                    position_next     = '0;
                    last_next         = 1'b1;
                    singular_next     = 1'b1;
                    clipped_next      = 1'b0;
                end
            end
            ST_DIV_RD: ;
            ST_DIV_LD:
            begin
                num      = NUM_W'(adj_rdata) <<< (2 * FRAC_BITS);
                mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                neg_next = adj_rdata[ADJ_W-1] ^ det_neg_reg;
                rem_next = CMP_W'(mag);
            end
            ST_DIV_CHK:
            begin
                over_next    = rem_reg >= {dmag_reg, {QB_W{1'b0}}};
                dsh_next     = CMP_W'(dmag_reg) << (QB_W - 1);
                q_next       = '0;
                bit_cnt_next = 6'(QB_W - 1);
            end
            ST_DIV_RUN:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next       = {q_reg[QB_W-2:0], ge};
                dsh_next     = dsh_reg >> 1;
                bit_cnt_next = bit_cnt_reg - 6'd1;
            end
            ST_DIV_OUT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    position_next     = k_reg;
                    last_next         = (k_reg == 4'd15);
                    singular_next     = 1'b0;
                    clipped_next      = clip;
                    if (clip)
                    begin
                        value_next = limit[ELEM_W-1:0];
                    end
                    else if (neg_reg)
                    begin
                        value_next = -q_reg[ELEM_W-1:0];
                    end
                    else
                    begin
                        value_next = q_reg[ELEM_W-1:0];
                    end
                    k_next = k_reg + 4'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            load_cnt_reg     <= '0;
            k_reg            <= '0;
            term_reg         <= '0;
            ph_reg           <= '0;
            bit_cnt_reg      <= '0;
            prod_vld_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            load_cnt_reg     <= load_cnt_next;
            k_reg            <= k_next;
            term_reg         <= term_next;
            ph_reg           <= ph_next;
            bit_cnt_reg      <= bit_cnt_next;
            prod_vld_reg     <= prod_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        prod_sh_reg  <= prod_sh_next;
        prod_neg_reg <= prod_neg_next;
        prod_det_reg <= prod_det_next;
        acc_reg      <= acc_next;
        det_reg      <= det_next;
        det_neg_reg  <= det_neg_next;
        dmag_reg     <= dmag_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        over_reg     <= over_next;
        value_reg    <= value_next;
        position_reg <= position_next;
        last_reg     <= last_next;
        singular_reg <= singular_next;
        clipped_reg  <= clipped_next;
    end

endmodule

// File: rtl/core/mi4_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/mi4_checker.sv
// port-level checks for the 4x4 matrix inverse block and their bind
// depends on matrix_inverse_4x4
module mi4_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               element_valid,
    input logic               element_stall,
    input logic signed [31:0] element,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] value,
    input logic [3:0]         position,
    input logic               last,
    input logic               singular,
    input logic               clipped
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(value) && $stable(position))
        else $error("stalled result changed");

    // singular result is a lone zero marker
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && singular |-> last && value == 32'sd0 && position == 4'd0 && !clipped)
        else $error("bad singular result");

    // saturation only to the two limits
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && clipped |-> value == 32'sh7FFFFFFF || value == 32'sh80000000)
        else $error("clipped value off limit");

    // the final result of a full inverse sits at the last position
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last && !singular |-> position == 4'd15)
        else $error("last flag off the final position");

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (.*);

// File: tb/sv/matrix_inverse_4x4_test.sv
// self-checking testbench for the 4x4 adjugate matrix inverse block
// depends on mi4_pkg and matrix_inverse_4x4; builds expected inverses with wide integer math
`timescale 1ns / 100ps

module matrix_inverse_4x4_test;
    import mi4_pkg::*;

    localparam int FRAC = 16;
    localparam int HOLD_CYCLES = 3000;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         position;
        logic               last;
        logic               singular;
        logic               clipped;
    } inv_elem_t;

    typedef struct {
        logic [31:0] data;
        logic        wait_drain;   // sender waits for every expected result first
    } elem_item_t;

    logic               clk;
    logic               rst_n;
    logic               element_valid;
    logic               element_stall;
    logic signed [31:0] element;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] value;
    logic [3:0]         position;
    logic               last;
    logic               singular;
    logic               clipped;

    matrix_inverse_4x4 #(.FRAC_BITS(FRAC)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .element_valid(element_valid),
        .element_stall(element_stall),
        .element      (element),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .position     (position),
        .last         (last),
        .singular     (singular),
        .clipped      (clipped)
    );

    // stimulus and expected-result stores
    elem_item_t         pending_elems[$];
    inv_elem_t          expected_inv[$];

    // predictor copy of the block's state
    logic signed [31:0] mat_copy[16];
    int                 load_idx;

    int                 errors;
    int                 accepted_elems;
    int                 matrices_done;
    int                 singular_seen;
    int                 clipped_seen;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 hold_count;
    bit                 hold_started;
    bit                 all_sent;
    bit                 in_taken;     // input transfer seen at the last rising edge

    // clock: 20 ns period
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // 3x3 minor of the stored matrix without row sr and column sc
    function automatic wide_t minor_det(input int sr, input int sc);
        int    rr[3];
        int    cc[3];
        int    n;
        wide_t e[3][3];
        n = 0;
        for (int k = 0; k < 4; k++)
            if (k != sr)
            begin
                rr[n] = k;
                n++;
            end
        n = 0;
        for (int k = 0; k < 4; k++)
            if (k != sc)
            begin
                cc[n] = k;
                n++;
            end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                e[a][b] = mat_copy[rr[a] * 4 + cc[b]];
        return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
             - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
             + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    endfunction

    // full inverse of the stored matrix, queued in row-major order
    task automatic predict_inverse();
        wide_t     adj[16];
        wide_t     det;
        wide_t     num;
        wide_t     dmag;
        wide_t     quot;
        wide_t     limit;
        bit        neg;
        inv_elem_t r;
        det = '0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
            begin
                adj[i * 4 + j] = minor_det(j, i);
                if ((i + j) % 2 == 1)
                    adj[i * 4 + j] = -adj[i * 4 + j];
            end
        for (int j = 0; j < 4; j++)
            det = det + adj[j * 4] * wide_t'(mat_copy[j]);
        if (det == 0)
        begin
            r.value = '0;
            r.position = '0;
            r.last = 1'b1;
            r.singular = 1'b1;
            r.clipped = 1'b0;
            expected_inv.push_back(r);
            singular_seen++;
            return;
        end
        dmag = (det < 0) ? -det : det;
        for (int k = 0; k < 16; k++)
        begin
            num = adj[k] <<< (2 * FRAC);
            neg = (num < 0) ^ (det < 0);
            if (num < 0)
                num = -num;
            quot = $unsigned(num) / $unsigned(dmag);
            limit = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
            r.position = k[3:0];
            r.last = (k == 15);
            r.singular = 1'b0;
            if (quot > limit)
            begin
                r.clipped = 1'b1;
                r.value = limit[31:0];
                clipped_seen++;
            end
            else
            begin
                r.clipped = 1'b0;
                r.value = neg ? -quot[31:0] : quot[31:0];
            end
            expected_inv.push_back(r);
        end
    endtask

    // monitor: input transfers feed the predictor, output transfers are checked
    always @(posedge clk)
    begin
        inv_elem_t exp_r;
        in_taken = rst_n && element_valid && !element_stall;
        if (rst_n && element_valid && !element_stall)
        begin
            mat_copy[load_idx] = element;
            accepted_elems++;
            if (load_idx == 15)
            begin
                load_idx = 0;
                matrices_done++;
                predict_inverse();
            end
            else
                load_idx++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_inv.size() == 0)
            begin
                $display("%0t: unexpected result value=%h position=%0d", $time, value, position);
                errors++;
            end
            else
            begin
                exp_r = expected_inv.pop_front();
                if (value !== exp_r.value)
                begin
                    $display("%0t: value mismatch expected %h actual %h", $time, exp_r.value,
                             value);
                    errors++;
                end
                if (position !== exp_r.position)
                begin
                    $display("%0t: position mismatch expected %0d actual %0d", $time,
                             exp_r.position, position);
                    errors++;
                end
                if (last !== exp_r.last)
                begin
                    $display("%0t: last mismatch expected %b actual %b", $time, exp_r.last, last);
                    errors++;
                end
                if (singular !== exp_r.singular)
                begin
                    $display("%0t: singular mismatch expected %b actual %b", $time,
                             exp_r.singular, singular);
                    errors++;
                end
                if (clipped !== exp_r.clipped)
                begin
                    $display("%0t: clipped mismatch expected %b actual %b", $time,
                             exp_r.clipped, clipped);
                    errors++;
                end
            end
        end
    end

    // driver: a new element goes out on the falling edge once the last one transferred
    always @(negedge clk)
    begin
        bit done_xfer;
        done_xfer = in_taken;
        if (!rst_n)
            element_valid <= 1'b0;
        else if (element_valid && !done_xfer)
        begin
            // payload held while stalled
        end
        else if (pending_elems.size() == 0)
            element_valid <= 1'b0;
        else if (pending_elems[0].wait_drain && expected_inv.size() != 0)
            element_valid <= 1'b0;
        else if ($urandom_range(99) < tx_idle_pct)
            element_valid <= 1'b0;
        else
        begin
            element <= pending_elems[0].data;
            element_valid <= 1'b1;
            pending_elems.pop_front();
        end
    end

    // receiver: random stall by phase, plus one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (!hold_started && accepted_elems >= 100)
            begin
                hold_started = 1'b1;
                hold_count = HOLD_CYCLES;
            end
            if (hold_count > 0)
            begin
                hold_count--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // idle rates follow the progress of the input side
    always @(posedge clk)
    begin
        if (accepted_elems < 160)
        begin
            tx_idle_pct <= 15;
            rx_idle_pct <= 57;
        end
        else if (accepted_elems < 320)
        begin
            tx_idle_pct <= 57;
            rx_idle_pct <= 15;
        end
        else
        begin
            tx_idle_pct <= 0;
            rx_idle_pct <= 0;
        end
    end

    task automatic queue_elem(input logic [31:0] d, input bit drain);
        elem_item_t it;
        it.data = d;
        it.wait_drain = drain;
        pending_elems.push_back(it);
    endtask

    // one random matrix; the style picks the kind of content
    task automatic queue_random_matrix(input bit drain);
        int          style;
        logic [31:0] row_copy[4];
        int          dup_row;
        logic [31:0] d;
        style = $urandom_range(9);
        dup_row = $urandom_range(1, 3);
        for (int k = 0; k < 16; k++)
        begin
            case (style)
                0, 1, 2: d = $urandom();
                3, 4, 5: d = $signed($urandom_range(262143)) - 131072;
                6, 7:    d = (k % 5 == 0) ? $urandom() : $signed($urandom_range(511)) - 256;
                default: d = $signed($urandom_range(2097151)) - 1048576;
            endcase
            // rank-deficient case: copy row zero into a later row
            if (style == 9 && k < 4)
                row_copy[k] = d;
            if (style == 9 && k / 4 == dup_row)
                d = row_copy[k % 4];
            queue_elem(d, drain && k == 0);
        end
    endtask

    initial
    begin
        logic [31:0] diag_vals[4];
        errors = 0;
        accepted_elems = 0;
        matrices_done = 0;
        singular_seen = 0;
        clipped_seen = 0;
        load_idx = 0;
        hold_count = 0;
        hold_started = 1'b0;
        all_sent = 1'b0;
        in_taken = 1'b0;
        tx_idle_pct = 15;
        rx_idle_pct = 57;
        rst_n = 1'b0;
        element_valid = 1'b0;
        element = '0;
        result_stall = 1'b0;

        // directed: diagonal of extremes gives clipping of both signs
        diag_vals = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        for (int k = 0; k < 16; k++)
            queue_elem((k % 5 == 0) ? diag_vals[k / 5] : 32'h0, 1'b0);
        // directed: all elements at the positive extreme, rank one so singular
        for (int k = 0; k < 16; k++)
            queue_elem(32'h7FFF_FFFF, 1'b0);
        // random matrices; one of them starts only after every result came back
        for (int m = 0; m < 28; m++)
            queue_random_matrix(m == 13);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_elems.size() == 0);
        @(posedge clk);
        wait (!element_valid && expected_inv.size() == 0);
        repeat (2000) @(posedge clk);

        $display("covered %0d matrices, %0d singular, %0d clipped results", matrices_done,
                 singular_seen, clipped_seen);
        if (errors == 0 && expected_inv.size() == 0)
            $display("matrix_inverse_4x4_test: PASS");
        else
            $display("matrix_inverse_4x4_test: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("matrix_inverse_4x4_test: FAIL");
        $finish;
    end

endmodule
